>>> hw/rtl/skf_pkg.sv
// Shared types and constants for the scalar Kalman filter.
// No dependencies; every other file of the block but skf_meas_if imports this package.
package skf_pkg;

  // Gain is an unsigned Q1.16 fraction, 0 .. 1.0 inclusive, so it needs 17 bits
  localparam int GAIN_BITS = 16;
  localparam int GAIN_W    = GAIN_BITS + 1;
  localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {GAIN_BITS{1'b0}}};

  // Configuration register map
  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_INIT_EST   = 2'd0;
  localparam cfg_idx_t CFG_INIT_ERR   = 2'd1;
  localparam cfg_idx_t CFG_PROC_NOISE = 2'd2;
  localparam cfg_idx_t CFG_MEAS_NOISE = 2'd3;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRED,
    ST_SUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MULX_GO,
    ST_MULX_WAIT,
    ST_MULP_GO,
    ST_MULP_WAIT,
    ST_UPDATE
  } skf_state_t;

endpackage

>>> hw/rtl/skf_meas_if.sv
// Measurement request channel: valid/ready handshake plus payload.
// Depends on nothing; width follows DATA_WIDTH.
interface skf_meas_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] measurement;
  logic                         restart;

  modport source (output valid, measurement, restart, input ready);
  modport sink   (input valid, measurement, restart, output ready);
endinterface

>>> hw/rtl/skf_result_if.sv
// Result channel: valid/ready handshake plus estimate, variance and gain.
// Depends on skf_pkg for the gain width.
interface skf_result_if #(parameter int DATA_WIDTH = 32);
  import skf_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] estimate;
  logic        [DATA_WIDTH-1:0] error_variance;
  logic        [GAIN_W-1:0]     gain;

  modport source (output valid, estimate, error_variance, gain, input ready);
  modport sink   (input valid, estimate, error_variance, gain, output ready);
endinterface

>>> hw/rtl/skf_div.sv
// Restoring divider for the Kalman gain, one quotient bit per cycle.
// Depends on skf_pkg (gain width). Quotient is forced to 0 for a zero divisor.
module skf_div #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [DATA_WIDTH-1:0]         dividend,
  input  logic [DATA_WIDTH:0]           divisor,
  output logic                          done,
  output logic [skf_pkg::GAIN_W-1:0]    quot
);
  import skf_pkg::*;

  localparam int CNT_W = $clog2(GAIN_W);

  logic [DATA_WIDTH:0]   rem_r, rem_nxt;
  logic [DATA_WIDTH:0]   dvs_r, dvs_nxt;
  logic [GAIN_W-1:0]     q_r, q_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DATA_WIDTH+1:0] trial;
  logic [DATA_WIDTH+1:0] rem_step;
  logic                  fit;

  // One trial subtraction; the first step compares without shifting
  always_comb begin
    trial    = (cnt_r == '0) ? {1'b0, rem_r} : {rem_r, 1'b0};
    fit      = (trial >= {1'b0, dvs_r});
    rem_step = fit ? (trial - {1'b0, dvs_r}) : trial;
  end

  // Step control
  always_comb begin
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = {1'b0, dividend};
      dvs_nxt  = divisor;
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the top bit drops out
      rem_nxt = rem_step[DATA_WIDTH:0];
      q_nxt   = {q_r[GAIN_W-2:0], fit};
      if (cnt_r == CNT_W'(GAIN_BITS)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = (dvs_r == '0) ? '0 : q_r;

endmodule

>>> hw/rtl/skf_mul.sv
// Shared multiplier: registered operands, then registered product.
// Depends on skf_pkg (gain width). Used for both the estimate and variance updates.
module skf_mul #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [DATA_WIDTH:0]                   mcand,
  input  logic [skf_pkg::GAIN_W-1:0]            mplier,
  output logic                                  done,
  output logic [DATA_WIDTH+skf_pkg::GAIN_W:0]   prod
);
  import skf_pkg::*;

  localparam int PROD_W = DATA_WIDTH + GAIN_W + 1;

  logic [DATA_WIDTH:0] a_r;
  logic [GAIN_W-1:0]   b_r;
  logic [PROD_W-1:0]   p_r;
  logic                v1_r;
  logic                done_r;

  // Valid pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      done_r <= v1_r;
    end
  end

  // Operand capture, then product
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= mcand;
      b_r <= mplier;
    end
    if (v1_r) begin
      p_r <= PROD_W'(a_r) * PROD_W'(b_r);
    end
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

>>> hw/rtl/scalar_kalman_filter.sv
// Scalar Kalman filter, signed fixed point, one measurement per request.
// A request is taken only in the idle state, so a new one waits until the previous
// result is written to the output register. The 17-step restoring divider forms the
// gain, and two passes go through the shared two-stage multiplier.
// Synchronous active-low reset loads the default noise and initial values and sets
// the estimate and variance from them; no result is pending after reset.
module scalar_kalman_filter #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  skf_meas_if.sink                 in_chan,
  skf_result_if.source             out_chan,
  input  logic                     cfg_we,
  input  skf_pkg::cfg_idx_t        cfg_index,
  input  logic [DATA_WIDTH-1:0]    cfg_wdata
);
  import skf_pkg::*;

  localparam int PROD_W = DATA_WIDTH + GAIN_W + 1;
  localparam longint unsigned FX_ONE = 64'd1 << FRAC_BITS;
  localparam logic [DATA_WIDTH-1:0] RST_ONE    = DATA_WIDTH'(FX_ONE);
  localparam logic [DATA_WIDTH-1:0] RST_PNOISE = DATA_WIDTH'((FX_ONE + 64'd50) / 64'd100);
  localparam logic [DATA_WIDTH-1:0] RST_MNOISE =
    DATA_WIDTH'((FX_ONE * 64'd10 + 64'd50) / 64'd100);

  // Configuration
  logic [DATA_WIDTH-1:0] init_est_r, init_err_r, pnoise_r, mnoise_r;

  // Filter state and working registers
  skf_state_t            state_r, state_nxt;
  logic [DATA_WIDTH-1:0] x_r, p_r, z_r, pp_r;
  logic [DATA_WIDTH:0]   sum_r, mag_r, dmag_r;
  logic                  neg_r;
  logic [GAIN_W-1:0]     q_r;

  // Output register
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_est_r, out_var_r;
  logic [GAIN_W-1:0]     out_gain_r;

  // Sequencer outputs
  logic in_rdy, div_start, mul_start, mul_sel_var, upd_fire, in_acc;

  // Datapath nets
  logic [DATA_WIDTH:0]   p_sum, resid, resid_mag, sum_nxt, x_upd, mcand;
  logic [DATA_WIDTH-1:0] pp_nxt;
  logic [GAIN_W-1:0]     mplier, div_quot;
  logic [PROD_W-1:0]     mul_prod;
  logic                  div_done, mul_done;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_chan.valid) state_nxt = ST_PRED;
      ST_PRED:      state_nxt = ST_SUM;
      ST_SUM:       state_nxt = ST_DIV_GO;
      ST_DIV_GO:    state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_done) state_nxt = ST_MULX_GO;
      ST_MULX_GO:   state_nxt = ST_MULX_WAIT;
      ST_MULX_WAIT: if (mul_done) state_nxt = ST_MULP_GO;
      ST_MULP_GO:   state_nxt = ST_MULP_WAIT;
      ST_MULP_WAIT: if (mul_done) state_nxt = ST_UPDATE;
      ST_UPDATE:    if (!out_valid_r || out_chan.ready) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_rdy      = (state_r == ST_IDLE);
    div_start   = (state_r == ST_DIV_GO);
    mul_start   = (state_r == ST_MULX_GO) || (state_r == ST_MULP_GO);
    mul_sel_var = (state_r == ST_MULP_GO);
    upd_fire    = (state_r == ST_UPDATE) && (!out_valid_r || out_chan.ready);
  end

  assign in_chan.ready = in_rdy;
  assign in_acc        = in_chan.valid && in_rdy;

  // Prediction with saturation, residual magnitude, gain denominator
  always_comb begin
    p_sum     = {1'b0, p_r} + {1'b0, pnoise_r};
    pp_nxt    = p_sum[DATA_WIDTH] ? '1 : p_sum[DATA_WIDTH-1:0];
    resid     = {z_r[DATA_WIDTH-1], z_r} - {x_r[DATA_WIDTH-1], x_r};
    resid_mag = resid[DATA_WIDTH] ? (~resid + 1'b1) : resid;
    sum_nxt   = {1'b0, pp_r} + {1'b0, mnoise_r};
  end

  // Shared multiplier operands: K*|z-x| first, then Pp*(1-K)
  always_comb begin
    mcand  = mul_sel_var ? {1'b0, pp_r} : mag_r;
    mplier = mul_sel_var ? (GAIN_ONE - q_r) : q_r;
  end

  // New estimate lies between x and z, so W+1 bits never overflow
  assign x_upd = {x_r[DATA_WIDTH-1], x_r} + (neg_r ? (~dmag_r + 1'b1) : dmag_r);

  skf_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (pp_r),
    .divisor  (sum_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  skf_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mcand),
    .mplier (mplier),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  // Control, configuration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      init_est_r  <= RST_ONE;
      init_err_r  <= RST_ONE;
      pnoise_r    <= RST_PNOISE;
      mnoise_r    <= RST_MNOISE;
      x_r         <= RST_ONE;
      p_r         <= RST_ONE;
    end else begin
      state_r <= state_nxt;

      if (upd_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INIT_EST:   init_est_r <= cfg_wdata;
          CFG_INIT_ERR:   init_err_r <= cfg_wdata;
          CFG_PROC_NOISE: pnoise_r   <= cfg_wdata;
          CFG_MEAS_NOISE: mnoise_r   <= cfg_wdata;
          default:        ;
        endcase
      end

      // restart reloads before this request's update
      if (in_acc && in_chan.restart) begin
        x_r <= init_est_r;
        p_r <= init_err_r;
      end
      if (state_r == ST_MULP_WAIT && mul_done) begin
        p_r <= mul_prod[DATA_WIDTH+GAIN_BITS-1:GAIN_BITS];
      end
      if (upd_fire) begin
        x_r <= x_upd[DATA_WIDTH-1:0];
      end
    end
  end

  // Working payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      z_r <= in_chan.measurement;
    end
    if (state_r == ST_PRED) begin
      pp_r  <= pp_nxt;
      neg_r <= resid[DATA_WIDTH];
      mag_r <= resid_mag;
    end
    if (state_r == ST_SUM) begin
      sum_r <= sum_nxt;
    end
    if (state_r == ST_DIV_WAIT && div_done) begin
      q_r <= div_quot;
    end
    if (state_r == ST_MULX_WAIT && mul_done) begin
      dmag_r <= mul_prod[DATA_WIDTH+GAIN_BITS:GAIN_BITS];
    end
    if (upd_fire) begin
      out_est_r  <= x_upd[DATA_WIDTH-1:0];
      out_var_r  <= p_r;
      out_gain_r <= q_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.estimate       = out_est_r;
  assign out_chan.error_variance = out_var_r;
  assign out_chan.gain           = out_gain_r;

  // Checks
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_MULX_WAIT || state_r == ST_MULP_WAIT))
    else $error("multiplier finished outside a wait state");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_gain_r <= GAIN_ONE)
    else $error("gain above one");

  a_var_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPDATE |-> p_r <= pp_r)
    else $error("updated variance exceeds predicted variance");

  a_zero_gain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_fire && q_r == '0) |=> x_r == $past(x_r))
    else $error("estimate moved with zero gain");

endmodule

>>> tb/tb.sv
// Self-checking bench for scalar_kalman_filter: directed corner requests, then random
// filter runs under several idling mixes, checked against an in-bench fixed-point update.
// Depends on skf_pkg, skf_meas_if, skf_result_if and the filter RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import skf_pkg::*;

  localparam int DW             = 32;
  localparam int SETTLE_CYCLES  = 40;    // longer than the request latency
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int BATCH_ITEMS    = 85;
  localparam int MAX_PRINTS     = 60;

  localparam logic [DW-1:0] DEF_INIT_EST   = 32'd65536;
  localparam logic [DW-1:0] DEF_INIT_ERR   = 32'd65536;
  localparam logic [DW-1:0] DEF_PROC_NOISE = 32'd655;
  localparam logic [DW-1:0] DEF_MEAS_NOISE = 32'd6554;
  localparam logic [DW-1:0] MEAS_MAX       = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] MEAS_MIN       = 32'h8000_0000;
  localparam logic [DW-1:0] ALL_ONES       = 32'hFFFF_FFFF;
  localparam longint unsigned VAR_SAT      = (64'd1 << DW) - 64'd1;

  typedef struct {
    logic signed [DW-1:0] measurement;
    logic                 restart;
  } meas_req_t;

  typedef struct {
    logic signed [DW-1:0] estimate;
    logic [DW-1:0]        error_variance;
    logic [GAIN_W-1:0]    gain;
  } kf_update_t;

  logic clk   = 1'b1;
  logic rst_n = 1'b0;

  logic           cfg_we    = 1'b0;
  cfg_idx_t       cfg_index = CFG_INIT_EST;
  logic [DW-1:0]  cfg_wdata = '0;

  skf_meas_if   #(.DATA_WIDTH(DW)) meas_ch ();
  skf_result_if #(.DATA_WIDTH(DW)) upd_ch ();

  scalar_kalman_filter #(.DATA_WIDTH(DW), .FRAC_BITS(16)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (meas_ch),
    .out_chan  (upd_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Filter state and register copies tracked by the bench
  logic signed [DW-1:0] est_now;
  logic [DW-1:0]        var_now;
  logic signed [DW-1:0] init_est_cfg;
  logic [DW-1:0]        init_err_cfg;
  logic [DW-1:0]        proc_noise_cfg;
  logic [DW-1:0]        meas_noise_cfg;

  meas_req_t  meas_backlog[$];
  kf_update_t predicted_updates[$];

  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  logic hold_on      = 1'b0;
  logic meas_taken   = 1'b0;
  int   quiet_cycles = 0;
  int   mismatches   = 0;

  always begin
    #10 clk = 1'b0;
    #10 clk = 1'b1;
  end

  // One filter step: predict variance, form the gain, move estimate and variance
  function automatic kf_update_t kalman_step(input meas_req_t req);
    longint unsigned p_pred, denom, k, mag, step, p_new;
    longint          resid;
    logic signed [DW-1:0] x_new;
    kf_update_t      upd;
    if (req.restart) begin
      est_now = init_est_cfg;
      var_now = init_err_cfg;
    end
    p_pred = 64'(var_now) + 64'(proc_noise_cfg);
    if (p_pred > VAR_SAT) p_pred = VAR_SAT;
    denom = p_pred + 64'(meas_noise_cfg);
    // gain = floor(Pp * 2^16 / (Pp + R)), zero for a zero denominator
    k = (denom == 0) ? 64'd0 : (p_pred << GAIN_BITS) / denom;
    resid = 64'(req.measurement) - 64'(est_now);
    mag   = (resid < 0) ? 64'(-resid) : 64'(resid);
    // step magnitude truncated, then signed by the residual
    step  = (mag * k) >> GAIN_BITS;
    x_new = (resid < 0) ? est_now - step[DW-1:0] : est_now + step[DW-1:0];
    p_new = (p_pred * (64'(GAIN_ONE) - k)) >> GAIN_BITS;
    est_now = x_new;
    var_now = p_new[DW-1:0];
    upd.estimate       = x_new;
    upd.error_variance = var_now;
    upd.gain           = k[GAIN_W-1:0];
    return upd;
  endfunction

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] MISMATCH %s", $time, what);
  endtask

  // Request driver: changes inputs on the falling edge
  always @(negedge clk) begin
    meas_req_t nxt;
    if (!rst_n) begin
      meas_ch.valid       <= 1'b0;
      meas_ch.measurement <= '0;
      meas_ch.restart     <= 1'b0;
    end else if (!meas_ch.valid || meas_taken) begin
      if (meas_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = meas_backlog.pop_front();
        meas_ch.valid       <= 1'b1;
        meas_ch.measurement <= nxt.measurement;
        meas_ch.restart     <= nxt.restart;
      end else begin
        meas_ch.valid <= 1'b0;
      end
    end
  end

  // Result ready: random stalls, or held low during the back-pressure stretch
  always @(negedge clk) begin
    if (!rst_n || hold_on)
      upd_ch.ready <= 1'b0;
    else
      upd_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Monitor: tracks register writes, predicts on each request, checks each result
  always @(posedge clk) begin
    kf_update_t want;
    meas_taken <= rst_n && meas_ch.valid && meas_ch.ready;
    if (!rst_n) begin
      init_est_cfg   <= DEF_INIT_EST;
      init_err_cfg   <= DEF_INIT_ERR;
      proc_noise_cfg <= DEF_PROC_NOISE;
      meas_noise_cfg <= DEF_MEAS_NOISE;
      est_now        <= DEF_INIT_EST;
      var_now        <= DEF_INIT_ERR;
      quiet_cycles   <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INIT_EST:   init_est_cfg   <= cfg_wdata;
          CFG_INIT_ERR:   init_err_cfg   <= cfg_wdata;
          CFG_PROC_NOISE: proc_noise_cfg <= cfg_wdata;
          CFG_MEAS_NOISE: meas_noise_cfg <= cfg_wdata;
          default: ;
        endcase
      end
      if (meas_ch.valid && meas_ch.ready)
        predicted_updates.push_back(kalman_step('{meas_ch.measurement, meas_ch.restart}));
      if (upd_ch.valid && upd_ch.ready) begin
        if (predicted_updates.size() == 0) begin
          report($sformatf("result with no request pending: est=%h var=%h gain=%h",
                           upd_ch.estimate, upd_ch.error_variance, upd_ch.gain));
        end else begin
          want = predicted_updates.pop_front();
          if (upd_ch.estimate !== want.estimate)
            report($sformatf("estimate got %h want %h", upd_ch.estimate, want.estimate));
          if (upd_ch.error_variance !== want.error_variance)
            report($sformatf("error_variance got %h want %h",
                             upd_ch.error_variance, want.error_variance));
          if (upd_ch.gain !== want.gain)
            report($sformatf("gain got %h want %h", upd_ch.gain, want.gain));
        end
      end
      // watchdog on cycles with no traffic at all
      if ((meas_ch.valid && meas_ch.ready) || (upd_ch.valid && upd_ch.ready) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_meas(input logic [DW-1:0] z, input logic rs);
    meas_req_t r;
    r.measurement = z;
    r.restart     = rs;
    meas_backlog.push_back(r);
  endtask

  task automatic set_idling(input int tx, input int rx);
    @(posedge clk);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
  endtask

  // Wait until every request is sent and answered, then let the pipe settle
  task automatic drain();
    while (meas_backlog.size() != 0 || meas_ch.valid || predicted_updates.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_all(input logic [DW-1:0] est, input logic [DW-1:0] err,
                           input logic [DW-1:0] pn, input logic [DW-1:0] mn);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_INIT_EST; cfg_wdata <= est;
    @(negedge clk);
    cfg_index <= CFG_INIT_ERR; cfg_wdata <= err;
    @(negedge clk);
    cfg_index <= CFG_PROC_NOISE; cfg_wdata <= pn;
    @(negedge clk);
    cfg_index <= CFG_MEAS_NOISE; cfg_wdata <= mn;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mix of zero, all-ones, full-range and small register values
  function automatic logic [DW-1:0] pick_cfg(input int unsigned small_max);
    case ($urandom_range(9))
      0:       return '0;
      1:       return ALL_ONES;
      2, 3:    return $urandom;
      default: return $urandom_range(small_max);
    endcase
  endfunction

  task automatic random_config();
    write_all(pick_cfg(32'h00FF_FFFF), pick_cfg(32'h0003_FFFF),
              pick_cfg(32'h0001_0000), pick_cfg(32'h0010_0000));
  endtask

  // Mostly a noisy random walk so the filter tracks, with full-range noise and extremes
  task automatic random_batch(input int n);
    int walk;
    int k;
    logic [DW-1:0] z;
    walk = $urandom;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0, 1, 2: z = $urandom;
        3:       z = $urandom_range(1) ? MEAS_MAX : MEAS_MIN;
        default: begin
          walk += int'($urandom_range(4096)) - 2048;
          z = walk + int'($urandom_range(512)) - 256;
        end
      endcase
      queue_meas(z, $urandom_range(99) < 8);
    end
  endtask

  task automatic random_phase(input int tx, input int rx);
    int b;
    set_idling(tx, rx);
    for (b = 0; b < 2; b++) begin
      random_config();
      random_batch(BATCH_ITEMS);
      drain();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults, extreme measurements, restart both ways
    queue_meas(MEAS_MAX, 1'b0);
    queue_meas(MEAS_MIN, 1'b0);
    queue_meas('0, 1'b1);
    queue_meas(ALL_ONES, 1'b0);
    queue_meas(32'h0001_0000, 1'b0);
    queue_meas(MEAS_MIN, 1'b1);
    drain();

    // saturated variance, zero measurement noise: unit gain, widest residuals
    write_all(MEAS_MIN, ALL_ONES, ALL_ONES, '0);
    queue_meas(MEAS_MAX, 1'b1);
    queue_meas(MEAS_MIN, 1'b1);
    queue_meas(MEAS_MAX, 1'b0);
    queue_meas(MEAS_MIN, 1'b0);
    drain();

    // all noise and variance zero: zero denominator, estimate frozen
    write_all(MEAS_MAX, '0, '0, '0);
    queue_meas(MEAS_MIN, 1'b1);
    queue_meas('0, 1'b0);
    queue_meas(32'h1234_5678, 1'b1);
    drain();

    // saturated prediction against maximal measurement noise
    write_all('0, ALL_ONES, 32'd1, ALL_ONES);
    queue_meas(MEAS_MAX, 1'b1);
    queue_meas(MEAS_MIN, 1'b0);
    queue_meas(32'h5555_5555, 1'b0);
    queue_meas(32'hAAAA_AAAA, 1'b1);
    drain();

    random_phase(0, 0);
    random_phase(58, 0);
    random_phase(0, 58);
    random_phase(18, 18);

    // back-pressure: results held off while requests keep coming
    set_idling(0, 0);
    random_config();
    random_batch(60);
    fork
      begin
        @(posedge clk);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
      end
    join_none
    drain();

    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/skf_pkg.sv
hw/rtl/skf_meas_if.sv
hw/rtl/skf_result_if.sv
hw/rtl/skf_div.sv
hw/rtl/skf_mul.sv
hw/rtl/scalar_kalman_filter.sv
tb/tb.sv
